### hdl/ups_pkg.sv
package ups_pkg;

  localparam int LEN_BITS  = 16;
  localparam int IDX_W     = LEN_BITS + 1;
  localparam int ENC_W     = LEN_BITS + 2;
  localparam int PREFIX_W  = 16;
  localparam int MAXLEN_W  = 16;
  localparam int INC_W     = 5;
  localparam int CONT_W    = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ADDR_W-3:0] REG_MAX_ENCODED_LEN = 1'b0;
  localparam logic [31:0]       MAX_ENCODED_LEN_RST = 32'd4096;

  typedef struct packed {
    logic              single;
    logic [INC_W-1:0]  enc_inc;
    logic [CONT_W-1:0] cont_init;
    logic              newline;
    logic              punct;
    logic              space;
  } ups_class_t;

endpackage

### hdl/ups_cfg.sv
module ups_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ups_pkg::ADDR_W-1:0]     paddr,
  input  logic [ups_pkg::DATA_W-1:0]     pwdata,
  output logic [ups_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output logic [ups_pkg::LEN_BITS-1:0]   max_len
);
  import ups_pkg::*;

  logic [LEN_BITS-1:0] max_len_r;
  logic [LEN_BITS-1:0] max_len_nxt;
  logic [31:0]         wr_val;
  logic [LEN_BITS+31:0] rd_ext;
  logic                sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[ADDR_W-1:2] == REG_MAX_ENCODED_LEN);
  assign wr_val  = {16'b0, pwdata[MAXLEN_W-1:0]};

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite && pready && sel_max) begin
      max_len_nxt = wr_val[LEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_ENCODED_LEN_RST[LEN_BITS-1:0];
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  assign rd_ext  = {32'b0, max_len_r};
  assign prdata  = sel_max ? rd_ext[DATA_W-1:0] : '0;
  assign max_len = max_len_r;

endmodule

### hdl/ups_classify.sv
module ups_classify (
  input  logic [7:0]          char_byte,
  output ups_pkg::ups_class_t cls
);
  import ups_pkg::*;

  logic unreserved;

  assign unreserved = (char_byte >= 8'h30 && char_byte <= 8'h39) ||
                      (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                      (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
                      char_byte == 8'h2D || char_byte == 8'h2E ||
                      char_byte == 8'h5F || char_byte == 8'h7E;

  always_comb begin
    cls.newline = (char_byte == 8'h0A);
    cls.punct   = (char_byte >= 8'h21 && char_byte <= 8'h2F) ||
                  (char_byte >= 8'h3A && char_byte <= 8'h40) ||
                  (char_byte >= 8'h5B && char_byte <= 8'h60) ||
                  (char_byte >= 8'h7B && char_byte <= 8'h7E);
    cls.space   = (char_byte == 8'h20) ||
                  (char_byte >= 8'h09 && char_byte <= 8'h0D);
    cls.single  = 1'b0;
    cls.enc_inc = 5'd3;
    cls.cont_init = 3'd0;
    case (char_byte[7:5])
      3'b110: begin
        cls.enc_inc   = 5'd6;
        cls.cont_init = 3'd1;
      end
      3'b111: begin
        if (!char_byte[4]) begin
          cls.enc_inc   = 5'd9;
          cls.cont_init = 3'd2;
        end else if (!char_byte[3]) begin
          cls.enc_inc   = 5'd12;
          cls.cont_init = 3'd3;
        end else if (!char_byte[2]) begin
          cls.enc_inc   = 5'd15;
          cls.cont_init = 3'd4;
        end else if (!char_byte[1]) begin
          cls.enc_inc   = 5'd18;
          cls.cont_init = 3'd5;
        end else begin
          cls.single  = 1'b1;
          cls.enc_inc = 5'd3;
        end
      end
      default: begin
        cls.single  = 1'b1;
        cls.enc_inc = unreserved ? 5'd1 : 5'd3;
      end
    endcase
  end

endmodule

### hdl/ups_track.sv
module ups_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          is_end,
  input  ups_pkg::ups_class_t           cls,
  input  logic [ups_pkg::LEN_BITS-1:0]  max_len,
  output logic [ups_pkg::PREFIX_W-1:0]  cut_len
);
  import ups_pkg::*;

  logic [IDX_W-1:0]  byte_index_r, byte_index_nxt;
  logic [ENC_W-1:0]  encoded_len_r, encoded_len_nxt;
  logic [CONT_W-1:0] cont_left_r, cont_left_nxt;
  logic [IDX_W-1:0]  break_pos_r, break_pos_nxt;
  logic [IDX_W-1:0]  punct_pos_r, punct_pos_nxt;
  logic [IDX_W-1:0]  space_pos_r, space_pos_nxt;
  logic              overflowed_r, overflowed_nxt;
  logic [IDX_W-1:0]  overflow_pos_r, overflow_pos_nxt;

  logic [ENC_W:0]    enc_sum;
  logic [ENC_W-1:0]  enc_sat;
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W-1:0]  idx_sat;
  logic [IDX_W-1:0]  cut_pos;
  logic [IDX_W+PREFIX_W-1:0] cut_ext;

  assign enc_sum = {1'b0, encoded_len_r} + {{(ENC_W+1-INC_W){1'b0}}, cls.enc_inc};
  assign enc_sat = enc_sum[ENC_W] ? {ENC_W{1'b1}} : enc_sum[ENC_W-1:0];
  assign idx_sum = {1'b0, byte_index_r} + {{IDX_W{1'b0}}, 1'b1};
  assign idx_sat = idx_sum[IDX_W] ? {IDX_W{1'b1}} : idx_sum[IDX_W-1:0];

  always_comb begin
    if (!overflowed_r) begin
      cut_pos = byte_index_r;
    end else if (break_pos_r != '0) begin
      cut_pos = break_pos_r;
    end else if (punct_pos_r != '0) begin
      cut_pos = punct_pos_r;
    end else if (space_pos_r != '0) begin
      cut_pos = space_pos_r;
    end else begin
      cut_pos = overflow_pos_r;
    end
  end

  assign cut_ext = {{PREFIX_W{1'b0}}, cut_pos};
  assign cut_len = cut_ext[PREFIX_W-1:0];

  always_comb begin
    byte_index_nxt   = byte_index_r;
    encoded_len_nxt  = encoded_len_r;
    cont_left_nxt    = cont_left_r;
    break_pos_nxt    = break_pos_r;
    punct_pos_nxt    = punct_pos_r;
    space_pos_nxt    = space_pos_r;
    overflowed_nxt   = overflowed_r;
    overflow_pos_nxt = overflow_pos_r;
    if (accept) begin
      if (is_end) begin
        byte_index_nxt   = '0;
        encoded_len_nxt  = '0;
        cont_left_nxt    = '0;
        break_pos_nxt    = '0;
        punct_pos_nxt    = '0;
        space_pos_nxt    = '0;
        overflowed_nxt   = 1'b0;
        overflow_pos_nxt = '0;
      end else if (!overflowed_r) begin
        if (cont_left_r != '0) begin
          cont_left_nxt  = cont_left_r - 3'd1;
          byte_index_nxt = idx_sat;
        end else begin
          encoded_len_nxt = enc_sat;
          if (enc_sat > {2'b0, max_len}) begin
            overflowed_nxt   = 1'b1;
            overflow_pos_nxt = byte_index_r;
          end else begin
            byte_index_nxt = idx_sat;
            cont_left_nxt  = cls.cont_init;
            if (cls.single) begin
              if (cls.newline) begin
                break_pos_nxt = idx_sat;
              end else if (cls.punct) begin
                punct_pos_nxt = idx_sat;
              end else if (cls.space) begin
                space_pos_nxt = idx_sat;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      encoded_len_r  <= '0;
      cont_left_r    <= '0;
      break_pos_r    <= '0;
      punct_pos_r    <= '0;
      space_pos_r    <= '0;
      overflowed_r   <= 1'b0;
      overflow_pos_r <= '0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      encoded_len_r  <= encoded_len_nxt;
      cont_left_r    <= cont_left_nxt;
      break_pos_r    <= break_pos_nxt;
      punct_pos_r    <= punct_pos_nxt;
      space_pos_r    <= space_pos_nxt;
      overflowed_r   <= overflowed_nxt;
      overflow_pos_r <= overflow_pos_nxt;
    end
  end

endmodule

### hdl/urlencoded_prefix_splitter.sv
// The splitter takes one string byte per beat and one beat per clock cycle; every byte's
// length and position bookkeeping is settled in the cycle it is accepted. A terminator
// beat returns the cut length from the output register on the following cycle, and the
// input stalls only while that register holds an undelivered result and out_stall is high.
module urlencoded_prefix_splitter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_byte,
  input  logic                           in_is_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ups_pkg::PREFIX_W-1:0]   out_prefix_len,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ups_pkg::ADDR_W-1:0]     paddr,
  input  logic [ups_pkg::DATA_W-1:0]     pwdata,
  output logic [ups_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import ups_pkg::*;

  logic [LEN_BITS-1:0] max_len;
  ups_class_t          cls;
  logic                in_accept;
  logic [PREFIX_W-1:0] cut_len;
  logic                out_valid_r, out_valid_nxt;
  logic [PREFIX_W-1:0] out_len_r, out_len_nxt;

  ups_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  ups_classify u_classify (
    .char_byte (in_char_byte),
    .cls       (cls)
  );

  ups_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .is_end  (in_is_end),
    .cls     (cls),
    .max_len (max_len),
    .cut_len (cut_len)
  );

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept && in_is_end) begin
      out_valid_nxt = 1'b1;
      out_len_nxt   = cut_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r <= out_len_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_prefix_len = out_len_r;

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ups_pkg::*;

  localparam int unsigned ENC_MAX = (1 << ENC_W) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1200;
  localparam int SETTLE_CYCLES = 4;

  class cut_len_scoreboard;
    bit [MAXLEN_W-1:0] max_len;
    bit [IDX_W-1:0]    byte_idx;
    bit [IDX_W-1:0]    nl_cut;
    bit [IDX_W-1:0]    punct_cut;
    bit [IDX_W-1:0]    space_cut;
    bit [IDX_W-1:0]    ovf_pos;
    bit [ENC_W-1:0]    enc_len;
    bit [CONT_W-1:0]   cont_left;
    bit                ovf;
    bit [PREFIX_W-1:0] expected_cuts[$];
    int                errors;
    int                overflows;
    int                checked;

    function new();
      max_len = MAX_ENCODED_LEN_RST[MAXLEN_W-1:0];
      clear_string();
    endfunction

    function void clear_string();
      byte_idx  = '0;
      nl_cut    = '0;
      punct_cut = '0;
      space_cut = '0;
      ovf_pos   = '0;
      enc_len   = '0;
      cont_left = '0;
      ovf       = 1'b0;
    endfunction

    function bit [IDX_W-1:0] idx_plus1(bit [IDX_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function bit [2:0] seq_len(bit [7:0] b);
      if (b < 8'hC0) return 3'd1;
      if (b < 8'hE0) return 3'd2;
      if (b < 8'hF0) return 3'd3;
      if (b < 8'hF8) return 3'd4;
      if (b < 8'hFC) return 3'd5;
      if (b < 8'hFE) return 3'd6;
      return 3'd1;
    endfunction

    function bit unreserved(bit [7:0] b);
      return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
             b == "-" || b == "." || b == "_" || b == "~";
    endfunction

    function bit is_punct(bit [7:0] b);
      return b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    endfunction

    function bit is_space(bit [7:0] b);
      return b == " " || (b inside {[8'h09:8'h0D]});
    endfunction

    function int pending();
      return expected_cuts.size();
    endfunction

    function void note_beat(bit [7:0] b, bit is_end);
      bit [IDX_W-1:0] cut;
      bit [2:0]       nbytes;
      int unsigned    sum;
      if (is_end) begin
        if (!ovf) cut = byte_idx;
        else if (nl_cut != 0) cut = nl_cut;
        else if (punct_cut != 0) cut = punct_cut;
        else if (space_cut != 0) cut = space_cut;
        else cut = ovf_pos;
        if (ovf) overflows++;
        expected_cuts.push_back(cut[PREFIX_W-1:0]);
        clear_string();
        return;
      end
      if (ovf) return;
      if (cont_left != 0) begin
        cont_left--;
        byte_idx = idx_plus1(byte_idx);
        return;
      end
      nbytes = seq_len(b);
      if (nbytes == 1) sum = enc_len + (unreserved(b) ? 1 : 3);
      else sum = enc_len + 3 * nbytes;
      enc_len = (sum > ENC_MAX) ? ENC_MAX[ENC_W-1:0] : sum[ENC_W-1:0];
      if (enc_len > max_len) begin
        ovf = 1'b1;
        ovf_pos = byte_idx;
        return;
      end
      if (nbytes == 1) begin
        if (b == "\n") nl_cut = idx_plus1(byte_idx);
        else if (is_punct(b)) punct_cut = idx_plus1(byte_idx);
        else if (is_space(b)) space_cut = idx_plus1(byte_idx);
      end else begin
        cont_left = nbytes - 3'd1;
      end
      byte_idx = idx_plus1(byte_idx);
    endfunction

    function void check_cut(bit [PREFIX_W-1:0] got);
      bit [PREFIX_W-1:0] want;
      checked++;
      if (expected_cuts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected prefix_len beat %0d with nothing pending", got);
        return;
      end
      want = expected_cuts.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("prefix_len mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_char_byte;
  logic                in_is_end;
  logic                out_valid;
  logic                out_stall;
  logic [PREFIX_W-1:0] out_prefix_len;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  cut_len_scoreboard sb;
  bit no_idle;
  int beats_sent;
  int strings_sent;
  int limits_written;
  int idle_cycles;

  urlencoded_prefix_splitter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_byte(in_char_byte),
    .in_is_end(in_is_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prefix_len(out_prefix_len),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_cut(out_prefix_len);
    end
  end

  task automatic send_beat(input bit [7:0] b, input bit is_end);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 19);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    in_is_end    <= is_end;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b, is_end);
    beats_sent++;
    if (is_end) strings_sent++;
  endtask

  task automatic send_seq(input bit [7:0] bytes[$]);
    foreach (bytes[i]) send_beat(bytes[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_string(input int nchars, input bit broken);
    string alnum;
    string puncts;
    bit [7:0] spaces[5];
    bit [7:0] lead;
    int r;
    int nb;
    alnum  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";
    puncts = "!\"#$%&'()*+,/:;<=>?@[\\]^`{|}";
    spaces = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    for (int i = 0; i < nchars; i++) begin
      r = $urandom_range(0, 99);
      if (broken || r >= 85) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 40) begin
        send_beat(alnum[$urandom_range(0, alnum.len() - 1)], 1'b0);
      end else if (r < 50) begin
        send_beat(puncts[$urandom_range(0, puncts.len() - 1)], 1'b0);
      end else if (r < 58) begin
        send_beat(spaces[$urandom_range(0, 4)], 1'b0);
      end else if (r < 65) begin
        send_beat("\n", 1'b0);
      end else begin
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(2, 4);
        case (nb)
          2: lead = 8'hC0 | 8'($urandom_range(0, 31));
          3: lead = 8'hE0 | 8'($urandom_range(0, 15));
          4: lead = 8'hF0 | 8'($urandom_range(0, 7));
          5: lead = 8'hF8 | 8'($urandom_range(0, 3));
          default: lead = 8'hFC | 8'($urandom_range(0, 1));
        endcase
        send_beat(lead, 1'b0);
        for (int k = 1; k < nb; k++) send_beat(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      end
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic write_max_len(input bit [MAXLEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_ENCODED_LEN, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.max_len = v;
    limits_written++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit [7:0] seq[$];
    bit [MAXLEN_W-1:0] lim;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_byte <= 8'h00;
    in_is_end    <= 1'b0;
    out_stall    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray continuation, 0xFF and a zero byte count 3 each; then a cut inside a
    // six-byte character and an empty string.
    write_max_len(16'hFFFF);
    seq = '{"Z", "~", "\n", "@", 8'h09, 8'hC3, 8'hA9, 8'h80, 8'hFF, 8'h00};
    send_seq(seq);
    seq = '{8'hFC, 8'h80};
    send_seq(seq);
    seq = {};
    send_seq(seq);
    drain();
    write_max_len(16'h0000);
    seq = '{"a"};
    send_seq(seq);
    drain();
    // The five-byte character overflows; the cut falls after the comma.
    write_max_len(16'd10);
    seq = '{"a", " ", "b", ",", 8'hF8, "x"};
    send_seq(seq);
    drain();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: lim = 16'd0;
        1: lim = 16'd1;
        2: lim = 16'd3;
        3: lim = 16'd8;
        4: lim = 16'd20;
        5: lim = 16'd45;
        6: lim = 16'd4096;
        7: lim = 16'hFFFF;
        default: lim = MAXLEN_W'($urandom_range(0, 120));
      endcase
      write_max_len(lim);
      repeat ($urandom_range(3, 8)) begin
        send_string($urandom_range(0, 30), $urandom_range(0, 7) == 0);
      end
      drain();
    end

    $display("Covered %0d random beats and %0d strings, %0d of them past the limit,",
             beats_sent, strings_sent, sb.overflows);
    $display("under %0d limit settings; checked %0d cut lengths with %0d mismatches.",
             limits_written, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ups_pkg.sv
hdl/ups_cfg.sv
hdl/ups_classify.sv
hdl/ups_track.sv
hdl/urlencoded_prefix_splitter.sv
bench/testbench.sv
